FILE: hw/rtl/scpd_pkg.sv
// ----------------------------------------------------------------------------
// scpd_pkg
// Shared types and constants of the scaled post column drawer: command codes,
// register indexes, fixed widths and the control/status bundles.
// ----------------------------------------------------------------------------
package scpd_pkg;

  localparam int unsigned SCREEN_WIDTH = 320;

  localparam logic [1:0] CMD_PAL_WRITE = 2'd0;
  localparam logic [1:0] CMD_START     = 2'd1;
  localparam logic [1:0] CMD_BYTE      = 2'd2;

  localparam logic [1:0] REG_VSTEP  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BASE   = 2'd2;

  localparam logic [7:0]  END_MARK    = 8'hff;
  localparam logic [23:0] MIN_STEP    = 24'd1024;
  localparam logic [10:0] ROW_MAX     = 11'd2047;
  localparam logic [6:0]  MAX_WRITES  = 7'd64;
  localparam logic [23:0] VSTEP_RST   = 24'd65536;
  localparam logic [10:0] HEIGHT_RST  = 11'd200;

  // controller to datapath
  typedef struct packed {
    logic pal_wr;     // store a palette entry
    logic col_start;  // open a new column
    logic load_top;   // take the post top byte
    logic load_len;   // take the post length byte
    logic adv;        // one row step towards the post top
    logic pal_rd;     // fetch the color of a data byte
    logic emit;       // load one pixel write into the output register
    logic next_byte;  // data byte done, bump the data index
  } scpd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adv_done;     // position reached the post top
    logic emit_ok;      // current row samples the current data byte
    logic emit_next_ok; // row after this one samples it too
    logic len_zero;     // empty post
    logic data_last;    // current data byte is the last of the post
    logic out_free;     // output register can take a pixel
  } scpd_stat_t;

endpackage

FILE: hw/rtl/scpd_ctrl.sv
// ----------------------------------------------------------------------------
// scpd_ctrl
// Post parser and sequencer: decodes input items, tracks the post phase and
// steps the datapath through position advance and pixel emission.
// ----------------------------------------------------------------------------
module scpd_ctrl import scpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] byte_value_i,
  input  scpd_stat_t stat_i,
  output scpd_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TOP  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_PAD1 = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_PAD2 = 3'd5;

  logic [1:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_PAL_WRITE: cmd_o.pal_wr = 1'b1;
            CMD_START: begin
              cmd_o.col_start = 1'b1;
              phase_d = PH_TOP;
            end
            CMD_BYTE: begin
              case (phase_q)
                PH_TOP: begin
                  if (byte_value_i == END_MARK) begin
                    phase_d = PH_IDLE;
                  end else begin
                    cmd_o.load_top = 1'b1;
                    phase_d = PH_LEN;
                    state_d = ST_ADV;
                  end
                end
                PH_LEN: begin
                  cmd_o.load_len = 1'b1;
                  phase_d = PH_PAD1;
                end
                PH_PAD1: phase_d = stat_i.len_zero ? PH_PAD2 : PH_DATA;
                PH_DATA: begin
                  cmd_o.pal_rd = 1'b1;
                  state_d = ST_EMIT;
                end
                PH_PAD2: phase_d = PH_TOP;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_ADV: begin
        if (stat_i.adv_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!stat_i.emit_ok) begin
          // byte samples no further row
          cmd_o.next_byte = 1'b1;
          state_d = ST_IDLE;
          if (stat_i.data_last) phase_d = PH_PAD2;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!stat_i.emit_next_ok) begin
            cmd_o.next_byte = 1'b1;
            state_d = ST_IDLE;
            if (stat_i.data_last) phase_d = PH_PAD2;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_IDLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

FILE: hw/rtl/scpd_datapath.sv
// ----------------------------------------------------------------------------
// scpd_datapath
// Configuration registers, palette memory, source position and row counters,
// pixel address generation and the output register.
// ----------------------------------------------------------------------------
module scpd_datapath import scpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [7:0]  byte_value_i,
  input  logic [31:0] palette_color_i,
  input  logic [11:0] dest_column_i,
  input  scpd_cmd_t   cmd_i,
  output scpd_stat_t  stat_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_address_o,
  output logic [31:0] pixel_color_o,
  output logic        last_of_run_o
);

  logic [23:0] vstep_q;
  logic [10:0] height_q;
  logic [31:0] base_q;

  logic [7:0]  top_q;
  logic [7:0]  len_q;
  logic [7:0]  idx_q;
  logic [31:0] pos_q, pos_d;
  logic [10:0] row_q, row_d;
  logic [11:0] col_q;
  logic [6:0]  cnt_q;
  logic [31:0] color_q;

  logic [31:0] palette_mem [256];

  logic        out_valid_q;
  logic [31:0] out_addr_q;
  logic [31:0] out_color_q;
  logic        out_last_q;

  logic [23:0] step;
  logic [31:0] pos_next;
  logic [31:0] target;
  logic [15:0] sample_row;
  logic [11:0] row_inc;
  logic [23:0] row_off;
  logic [31:0] addr;
  logic [7:0]  idx_inc;

  assign step       = (vstep_q < MIN_STEP) ? MIN_STEP : vstep_q;
  assign pos_next   = pos_q + {8'd0, step};
  assign target     = {8'd0, top_q, 16'd0};
  assign sample_row = {7'd0, ({1'b0, top_q} + {1'b0, idx_q})};
  assign row_inc    = {1'b0, row_q} + 12'd1;
  assign row_off    = 24'(row_q) * 24'(SCREEN_WIDTH);
  assign addr       = base_q + {20'd0, col_q} + {8'd0, row_off};
  assign idx_inc    = idx_q + 8'd1;

  assign stat_o.adv_done     = !(pos_q < target);
  assign stat_o.emit_ok      = (cnt_q < MAX_WRITES) && (row_q < height_q) &&
                               (pos_q[31:16] == sample_row);
  assign stat_o.emit_next_ok = (cnt_q != (MAX_WRITES - 7'd1)) &&
                               (row_inc < {1'b0, height_q}) &&
                               (pos_next[31:16] == sample_row);
  assign stat_o.len_zero     = (len_q == 8'd0);
  assign stat_o.data_last    = !(idx_inc < len_q);
  assign stat_o.out_free     = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vstep_q  <= VSTEP_RST;
      height_q <= HEIGHT_RST;
      base_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VSTEP:  vstep_q  <= cfg_data_i[23:0];
        REG_HEIGHT: height_q <= cfg_data_i[10:0];
        REG_BASE:   base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d = pos_q;
    row_d = row_q;
    if (cmd_i.col_start) begin
      pos_d = '0;
      row_d = '0;
    end else if (cmd_i.adv) begin
      pos_d = pos_next;
      if (row_q != ROW_MAX) row_d = row_inc[10:0];
    end else if (cmd_i.emit) begin
      pos_d = pos_next;
      row_d = row_inc[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      len_q <= '0;
      idx_q <= '0;
      pos_q <= '0;
      row_q <= '0;
      col_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      row_q <= row_d;
      if (cmd_i.col_start) begin
        col_q <= dest_column_i;
        top_q <= '0;
        len_q <= '0;
        idx_q <= '0;
      end
      if (cmd_i.load_top) top_q <= byte_value_i;
      if (cmd_i.load_len) begin
        len_q <= byte_value_i;
        idx_q <= '0;
      end
      if (cmd_i.next_byte) idx_q <= idx_inc;
      if (cmd_i.pal_rd) begin
        cnt_q <= '0;
      end else if (cmd_i.emit) begin
        cnt_q <= cnt_q + 7'd1;
      end
    end
  end

  // palette store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.pal_wr) palette_mem[byte_value_i] <= palette_color_i;
    if (cmd_i.pal_rd) color_q <= palette_mem[byte_value_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_addr_q  <= addr;
      out_color_q <= color_q;
      out_last_q  <= !stat_o.emit_next_ok;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_color_o   = out_color_q;
  assign last_of_run_o   = out_last_q;

endmodule

FILE: hw/rtl/scaled_post_column_drawer.sv
// ----------------------------------------------------------------------------
// scaled_post_column_drawer
// Draws one sprite column in post format into a framebuffer, scaled
// vertically, one pixel write per output item.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) takes palette writes, start
//   column commands and column stream bytes; an item is taken when valid is
//   high and stall is low.
//   output channel (out_valid_o / out_stall_i) carries pixel writes, with
//   last_of_run_o marking the final write caused by one input item.
//   config channel (cfg_valid_i / cfg_ready_o) writes vertical step, drawn
//   height and frame base; always ready, write only while idle.
// timing:
//   palette writes, start column, pad/length bytes: taken without a stall.
//   post top byte: the input stalls while the sequencer steps the position
//   to the top (sequencer adds one step per cycle).
//   data byte: a palette read, then pixel writes as long as the output
//   register is free, at most 64 writes; the input stalls meanwhile.
//   first pixel passes the palette read register, then the output register.
// reset clears the control state and loads default register values; the
// palette holds nothing until written. a stalled receiver holds the output
// register and stops the emit sequence, which in turn stalls the input.
// ----------------------------------------------------------------------------
module scaled_post_column_drawer import scpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  byte_value_i,
  input  logic [31:0] palette_color_i,
  input  logic [11:0] dest_column_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_address_o,
  output logic [31:0] pixel_color_o,
  output logic        last_of_run_o
);

  scpd_cmd_t  ctrl_cmd;
  scpd_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  scpd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .byte_value_i (byte_value_i),
    .stat_i       (dp_stat),
    .cmd_o        (ctrl_cmd)
  );

  scpd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .byte_value_i    (byte_value_i),
    .palette_color_i (palette_color_i),
    .dest_column_i   (dest_column_i),
    .cmd_i           (ctrl_cmd),
    .stat_o          (dp_stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_address_o (pixel_address_o),
    .pixel_color_o   (pixel_color_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for scaled_post_column_drawer
// Feeds palette writes, column starts and post-format stream bytes under
// several vertical step, height and frame base settings. It keeps its own
// model of the column parser and the scaler and compares every pixel write,
// in order, against it. Both channels idle at random in the tests that throttle them.
// ----------------------------------------------------------------------------
module testbench;
  import scpd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    COL_IDLE, COL_TOP, COL_LEN, COL_PAD1, COL_DATA, COL_PAD2
  } column_phase_e;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] color;
    logic        last;
  } pixel_write_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [7:0]  byte_value_i;
  logic [31:0] palette_color_i;
  logic [11:0] dest_column_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] pixel_address_o;
  logic [31:0] pixel_color_o;
  logic        last_of_run_o;

  scaled_post_column_drawer uut (.*);

  // scaler model state
  logic [23:0]   step_cfg;
  logic [10:0]   height_cfg;
  logic [31:0]   base_cfg;
  column_phase_e col_phase;
  logic [7:0]    post_top;
  logic [7:0]    post_len;
  logic [7:0]    data_idx;
  logic [31:0]   src_pos;
  logic [10:0]   row;
  logic [11:0]   col_x;
  logic [31:0]   color_table [256];
  bit            color_written [256];

  pixel_write_t    expected_writes [$];
  longint unsigned last_adv_rows = 0;
  bit              item_ignored;

  bit tx_throttle = 1'b0;
  bit rx_throttle = 1'b0;
  int unsigned items_sent = 0;
  int unsigned live_items = 0;
  int unsigned settings_used = 0;
  int unsigned writes_checked = 0;
  int unsigned mismatches = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (5_000_000) @(posedge clk_i);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 25) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [31:0] step_in_use();
    return (step_cfg < MIN_STEP) ? 32'(MIN_STEP) : 32'(step_cfg);
  endfunction

  function automatic logic [7:0] any_written_color();
    logic [7:0] i;
    i = 8'($urandom_range(255));
    while (!color_written[i]) i = 8'($urandom_range(255));
    return i;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!tx_throttle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(20, 6);
  endfunction

  // step the position to the post top, one row per step, no writes
  task automatic advance_to_top();
    logic [31:0]     target;
    logic [31:0]     s;
    longint unsigned n;
    longint unsigned rows;
    target = {8'd0, post_top, 16'd0};
    s = step_in_use();
    if (src_pos < target) begin
      n = (64'(target - src_pos) + 64'(s) - 1) / 64'(s);
      rows = 64'(row) + n;
      src_pos = 32'(64'(src_pos) + n * 64'(s));
      row = (rows > 64'(ROW_MAX)) ? ROW_MAX : rows[10:0];
      last_adv_rows = n;
    end
  endtask

  // every row that samples this data byte gets one write, up to 64 writes and within the drawn height
  task automatic emit_data_byte(input logic [7:0] value);
    pixel_write_t run [$];
    pixel_write_t w;
    logic [31:0]  s;
    s = step_in_use();
    while (run.size() < MAX_WRITES && row < height_cfg &&
           src_pos[31:16] >= {8'd0, post_top} &&
           (src_pos[31:16] - {8'd0, post_top}) == {8'd0, data_idx}) begin
      w.addr  = base_cfg + 32'(col_x) + 32'(row) * 32'(SCREEN_WIDTH);
      w.color = color_table[value];
      w.last  = 1'b0;
      run.push_back(w);
      src_pos = src_pos + s;
      row = row + 11'd1;
    end
    if (run.size() != 0) run[run.size() - 1].last = 1'b1;
    foreach (run[k]) expected_writes.push_back(run[k]);
  endtask

  task automatic predict_item(input logic [1:0] cmd, input logic [7:0] value,
                              input logic [31:0] color, input logic [11:0] column);
    item_ignored = 1'b0;
    last_adv_rows = 0;
    case (cmd)
      CMD_PAL_WRITE: begin
        color_table[value] = color;
        color_written[value] = 1'b1;
      end
      CMD_START: begin
        col_x = column;
        src_pos = '0;
        row = '0;
        post_top = '0;
        post_len = '0;
        data_idx = '0;
        col_phase = COL_TOP;
      end
      CMD_BYTE: begin
        case (col_phase)
          COL_TOP: begin
            if (value == END_MARK) begin
              col_phase = COL_IDLE;
            end else begin
              post_top = value;
              advance_to_top();
              col_phase = COL_LEN;
            end
          end
          COL_LEN: begin
            post_len = value;
            data_idx = '0;
            col_phase = COL_PAD1;
          end
          COL_PAD1: col_phase = (post_len == 0) ? COL_PAD2 : COL_DATA;
          COL_DATA: begin
            emit_data_byte(value);
            data_idx = data_idx + 8'd1;
            if (data_idx >= post_len) col_phase = COL_PAD2;
          end
          COL_PAD2: col_phase = COL_TOP;
          default: item_ignored = 1'b1;
        endcase
      end
      default: item_ignored = 1'b1;
    endcase
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] value,
                           input logic [31:0] color, input logic [11:0] column);
    int unsigned gap;
    gap = pick_gap();
    // data bytes only ever point at palette entries already written
    if (cmd == CMD_BYTE && col_phase == COL_DATA && !color_written[value])
      value = any_written_color();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = cmd;
    byte_value_i = value;
    palette_color_i = color;
    dest_column_i = column;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_item(cmd, value, color, column);
    items_sent++;
    if (!item_ignored) live_items++;
  endtask

  task automatic send_byte(input logic [7:0] value);
    send_item(CMD_BYTE, value, $urandom, 12'($urandom_range(4095)));
  endtask

  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_writes.size() != 0 && waited < 200_000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_writes.size() != 0) begin
      report_mismatch($sformatf("%0d pixel writes never arrived", expected_writes.size()));
      expected_writes.delete();
    end
    // a post top with no writes may still be stepping
    repeat (last_adv_rows + 140) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      REG_VSTEP:  step_cfg = value[23:0];
      REG_HEIGHT: height_cfg = value[10:0];
      REG_BASE:   base_cfg = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic apply_setting(input logic [23:0] vstep, input logic [10:0] height,
                               input logic [31:0] base);
    wait_idle();
    write_register(REG_VSTEP, 32'(vstep));
    write_register(REG_HEIGHT, 32'(height));
    write_register(REG_BASE, base);
    settings_used++;
  endtask

  // one column with random posts, now and then with noise or cut short
  task automatic draw_random_column();
    int unsigned posts;
    int unsigned len;
    int unsigned top;
    int unsigned cap;
    if ($urandom_range(99) < 20)
      send_item(CMD_PAL_WRITE, 8'($urandom_range(255)), $urandom,
                12'($urandom_range(4095)));
    if ($urandom_range(99) < 8) send_byte(8'($urandom_range(255)));
    if ($urandom_range(99) < 5)
      send_item(CMD_UNUSED, 8'($urandom_range(255)), $urandom, 12'($urandom_range(4095)));
    send_item(CMD_START, 8'($urandom_range(255)), $urandom, 12'($urandom_range(4095)));
    cap = (step_in_use() < 16384) ? 40 : 254;
    posts = $urandom_range(4, 1);
    top = $urandom_range(cap / 4);
    for (int p = 0; p < posts; p++) begin
      send_byte(8'(top));
      len = ($urandom_range(99) < 12) ? 0 : $urandom_range(5, 1);
      send_byte(8'(len));
      // broken post: the next start command discards it
      if ($urandom_range(99) < 6) return;
      send_byte(8'($urandom_range(255)));
      for (int d = 0; d < len; d++) begin
        if ($urandom_range(99) < 4)
          send_item(CMD_PAL_WRITE, 8'($urandom_range(255)), $urandom,
                    12'($urandom_range(4095)));
        send_byte(any_written_color());
      end
      send_byte(8'($urandom_range(255)));
      top = top + len + $urandom_range(cap / 4);
      if (top > cap) break;
    end
    if ($urandom_range(99) < 92) send_byte(END_MARK);
  endtask

  task automatic run_columns(input int unsigned count);
    int unsigned goal;
    goal = live_items + count;
    while (live_items < goal) draw_random_column();
  endtask

  task automatic test_directed_stream();
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    send_item(CMD_PAL_WRITE, 8'h00, 32'hffff_ffff, 12'h000);
    send_item(CMD_PAL_WRITE, 8'hff, 32'h0000_0000, 12'hfff);
    send_item(CMD_PAL_WRITE, 8'h55, 32'ha5a5_a5a5, 12'h555);
    send_item(CMD_PAL_WRITE, 8'haa, 32'h5a5a_5a5a, 12'haaa);
    // no column open yet, and an unknown command
    send_byte(8'h37);
    send_item(CMD_UNUSED, 8'hff, 32'hffff_ffff, 12'hfff);
    send_item(CMD_START, 8'h00, 32'h0, 12'hfff);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h11);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h22);
    // empty post
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h44);
    send_byte(8'h44);
    // restart in the middle of a post
    send_byte(8'h0a);
    send_byte(8'h03);
    send_item(CMD_START, 8'h00, 32'h0, 12'h000);
    // top below the drawn height
    send_byte(8'hfe);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'haa);
    send_byte(8'h00);
    send_byte(END_MARK);
  endtask

  task automatic test_min_step_wrapping_base();
    apply_setting(24'd1024, 11'd1024, 32'hffff_ffff);
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    run_columns(12);
  endtask

  task automatic test_zero_step_row_limit();
    apply_setting(24'd0, 11'd2047, 32'h0000_0000);
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    // a top far enough down to pin the row counter
    send_item(CMD_START, 8'h00, 32'h0, 12'h123);
    send_byte(8'd40);
    send_byte(8'd1);
    send_byte(8'h00);
    send_byte(any_written_color());
    send_byte(8'h00);
    send_byte(END_MARK);
    run_columns(8);
  endtask

  task automatic test_max_step_one_row();
    apply_setting(24'hff_ffff, 11'd1, 32'h8000_0000);
    tx_throttle = 1'b1;
    rx_throttle = 1'b0;
    run_columns(10);
  endtask

  task automatic test_zero_height();
    apply_setting(24'h01_8000, 11'd0, $urandom);
    tx_throttle = 1'b0;
    rx_throttle = 1'b1;
    run_columns(8);
  endtask

  task automatic test_random_settings();
    apply_setting(24'h00_8000, 11'd320, $urandom);
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    run_columns(10);
    apply_setting(24'd500, 11'($urandom_range(1024, 1)), $urandom);
    tx_throttle = 1'b0;
    rx_throttle = 1'b1;
    run_columns(10);
    apply_setting(24'($urandom_range(24'h03_0000, 1024)), 11'($urandom_range(1024, 1)),
                  $urandom);
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    run_columns(10);
  endtask

  // receiver pacing: mostly short stalls, now and then a long one
  initial begin : receiver_pacing
    int unsigned hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if (rx_throttle && $urandom_range(99) < 40) begin
        out_stall_i = 1'b1;
        hold = ($urandom_range(99) < 90) ? $urandom_range(2) : $urandom_range(25, 8);
      end else begin
        out_stall_i = 1'b0;
        hold = rx_throttle ? $urandom_range(5) : 0;
      end
    end
  end

  always @(posedge clk_i) begin : check_writes
    pixel_write_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      writes_checked++;
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel write to %h", pixel_address_o));
      end else begin
        want = expected_writes.pop_front();
        if (pixel_address_o !== want.addr)
          report_mismatch($sformatf("address %h, expected %h", pixel_address_o, want.addr));
        if (pixel_color_o !== want.color)
          report_mismatch($sformatf("color %h at %h, expected %h", pixel_color_o,
                                    want.addr, want.color));
        if (last_of_run_o !== want.last)
          report_mismatch($sformatf("last flag %b at %h, expected %b", last_of_run_o,
                                    want.addr, want.last));
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_VSTEP;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cmd_i = CMD_PAL_WRITE;
    byte_value_i = '0;
    palette_color_i = '0;
    dest_column_i = '0;
    step_cfg = VSTEP_RST;
    height_cfg = HEIGHT_RST;
    base_cfg = '0;
    col_phase = COL_IDLE;
    post_top = '0;
    post_len = '0;
    data_idx = '0;
    src_pos = '0;
    row = '0;
    col_x = '0;
    foreach (color_written[i]) color_written[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_stream();
    test_min_step_wrapping_base();
    test_zero_step_row_limit();
    test_max_step_one_row();
    test_zero_height();
    test_random_settings();
    wait_idle();

    $display("covered %0d input items (%0d not ignored) across %0d register settings",
             items_sent, live_items, settings_used);
    $display("checked %0d pixel writes, %0d mismatches", writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/scpd_pkg.sv
hw/rtl/scpd_ctrl.sv
hw/rtl/scpd_datapath.sv
hw/rtl/scaled_post_column_drawer.sv
tb/testbench.sv
